[rtl/assert_macros.svh]
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/bsfd_pkg.sv]
package bsfd_pkg;

	// link control codes
	localparam logic [7:0] CODE_START  = 8'h00;
	localparam logic [7:0] CODE_ESCAPE = 8'h01;
	localparam logic [7:0] CODE_STOP   = 8'h02;
	localparam logic [7:0] ESC_OFFSET  = 8'h03;

	// width of the frame length field
	localparam int LEN_W = 6;

	typedef enum logic [1:0] {
		KIND_START,
		KIND_ESCAPE,
		KIND_STOP,
		KIND_DATA
	} byte_kind_t;

	typedef enum logic {
		RX_IDLE,
		RX_FRAME
	} rx_state_t;

	// frame close event from receiver to read-out sequencer
	typedef struct packed {
		logic             fire;
		logic [LEN_W-1:0] len;
	} close_t;

	function automatic byte_kind_t classify(input logic [7:0] b);
		byte_kind_t k;
		unique case (b)
			CODE_START:  k = KIND_START;
			CODE_ESCAPE: k = KIND_ESCAPE;
			CODE_STOP:   k = KIND_STOP;
			default:     k = KIND_DATA;
		endcase
		return k;
	endfunction

endpackage

[rtl/bsfd_ram.sv]
module bsfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single write port, registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[rtl/bsfd_rx.sv]
module bsfd_rx #(
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [7:0]               in_byte,
	input  logic                     busy,
	output logic                     wr_en,
	output logic [$clog2(DEPTH)-1:0] wr_addr,
	output logic [7:0]               wr_data,
	output bsfd_pkg::close_t         close
);

	import bsfd_pkg::*;

	localparam int CW = $clog2(DEPTH);
	localparam logic [CW-1:0] LAST_SLOT = CW'(DEPTH - 1);

	rx_state_t     state_q, state_d;
	logic          escape_q;
	logic [CW-1:0] count_q;
	logic          accept;
	byte_kind_t    kind;
	logic          full;

	assign in_ready = !busy;
	assign accept   = in_valid && in_ready;
	assign kind     = classify(in_byte);
	assign full     = (count_q == LAST_SLOT);

	// next state
	always_comb begin
		state_d = state_q;
		if (accept) begin
			unique case (state_q)
				RX_IDLE: begin
					if (kind == KIND_START) state_d = RX_FRAME;
				end
				RX_FRAME: begin
					unique case (kind) inside
						KIND_START, KIND_ESCAPE: state_d = RX_FRAME;
						KIND_STOP:               state_d = RX_IDLE;
						default:                 state_d = full ? RX_IDLE : RX_FRAME;
					endcase
				end
				default: state_d = RX_IDLE;
			endcase
		end
	end

	// buffer write and frame close
	always_comb begin
		wr_en      = 1'b0;
		close.fire = 1'b0;
		close.len  = LEN_W'(count_q);
		unique case (state_q)
			RX_FRAME: begin
				wr_en      = accept && (kind == KIND_DATA);
				close.fire = accept && (kind == KIND_STOP) && (count_q != '0);
			end
			default: begin
				wr_en      = 1'b0;
				close.fire = 1'b0;
			end
		endcase
	end

	assign wr_addr   = count_q;
	assign wr_data   = escape_q ? (in_byte - ESC_OFFSET) : in_byte;

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= RX_IDLE;
			escape_q <= 1'b0;
			count_q  <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (kind == KIND_START) begin
					escape_q <= 1'b0;
					count_q  <= '0;
				end else if (state_q == RX_FRAME) begin
					case (kind)
						KIND_ESCAPE: escape_q <= 1'b1;
						KIND_STOP: begin
							escape_q <= 1'b0;
							count_q  <= '0;
						end
						default: begin
							escape_q <= 1'b0;
							count_q  <= full ? '0 : count_q + 1'b1;
						end
					endcase
				end
			end
		end
	end

endmodule

[rtl/bsfd_tx.sv]
module bsfd_tx #(
	parameter int DEPTH = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bsfd_pkg::close_t           close,
	output logic                       busy,
	output logic                       rd_en,
	output logic [$clog2(DEPTH)-1:0]   rd_addr,
	input  logic [7:0]                 rd_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [7:0]                 out_byte,
	output logic                       last_byte,
	output logic [bsfd_pkg::LEN_W-1:0] frame_length
);

	import bsfd_pkg::*;

	localparam int CW = $clog2(DEPTH);

	logic          drain_q;
	logic [CW-1:0] ptr_q;
	logic [CW-1:0] len_q;
	logic          rd_s1;
	logic          last_s1;
	logic          out_valid_q;
	logic          out_fire;
	logic          is_last;

	assign busy      = drain_q;
	assign out_valid = out_valid_q;
	assign out_fire  = out_valid_q && out_ready;
	assign is_last   = (ptr_q == len_q - 1'b1);

	// one read in flight, only when the output register is free next cycle
	assign rd_en   = drain_q && !rd_s1 && (!out_valid_q || out_fire);
	assign rd_addr = ptr_q;

	// read-out sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q <= 1'b0;
			ptr_q   <= '0;
			len_q   <= '0;
			rd_s1   <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			rd_s1 <= rd_en;
			if (close.fire) begin
				drain_q <= 1'b1;
				ptr_q   <= '0;
				len_q   <= CW'(close.len);
			end else if (rd_en) begin
				ptr_q   <= ptr_q + 1'b1;
				last_s1 <= is_last;
				if (is_last) drain_q <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rd_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_s1) begin
			out_byte     <= rd_data;
			last_byte    <= last_s1;
			frame_length <= LEN_W'(len_q);
		end
	end

endmodule

[rtl/byte_stuffed_frame_decoder.sv]
// channel   direction  payload                              handshake
// in        input      in_byte                              in_valid / in_ready
// out       output     out_byte, last_byte, frame_length    out_valid / out_ready
//
// one input item per cycle while a frame is being received
// on a non-empty stop item input is held off while the frame is read back from the
// buffer ram; a new read waits for the single read in flight and for a free output register
// the frame payload lives in one BUF_DEPTH x 8 ram, written at the fill count
// arst_n clears frame state, fill count and output valid; the ram needs no clearing
// a stalled output holds its item; input reopens once the last read is issued
`include "assert_macros.svh"

module byte_stuffed_frame_decoder #(
	parameter int BUF_DEPTH = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 in_byte,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [7:0]                 out_byte,
	output logic                       last_byte,
	output logic [bsfd_pkg::LEN_W-1:0] frame_length
);

	import bsfd_pkg::*;

	localparam int AW = $clog2(BUF_DEPTH);

	logic          busy;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;
	close_t        close;

	// receive side: unstuffing and buffer fill
	bsfd_rx #(.DEPTH(BUF_DEPTH)) u_rx (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.busy     (busy),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.close    (close)
	);

	// payload buffer
	bsfd_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// frame read-out
	bsfd_tx #(.DEPTH(BUF_DEPTH)) u_tx (
		.clk          (clk),
		.arst_n       (arst_n),
		.close        (close),
		.busy         (busy),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.last_byte    (last_byte),
		.frame_length (frame_length)
	);

	// checks
	`ASSERT_IMP(a_no_write_in_drain, clk, arst_n, wr_en, !busy)
	`ASSERT_NXT(a_close_starts_drain, clk, arst_n, close.fire, busy)
	`ASSERT_IMP(a_len_nonzero, clk, arst_n, out_valid, frame_length != '0)

endmodule

[bench/byte_stuffed_frame_decoder_tb.sv]
`timescale 1ns / 100ps

module byte_stuffed_frame_decoder_tb;

	import bsfd_pkg::*;

	localparam int BUF_DEPTH      = 64;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 20;

	// one decoded payload item as the decoder should present it
	typedef struct {
		logic [7:0]       data;
		logic             last;
		logic [LEN_W-1:0] len;
	} payload_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [7:0]       in_byte = 8'h00;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [7:0]       out_byte;
	logic             last_byte;
	logic [LEN_W-1:0] frame_length;

	// shadow of the receiver state
	logic       rx_open = 1'b0;
	logic       esc_mark = 1'b0;
	int         fill = 0;
	logic [7:0] frame_buf [BUF_DEPTH];

	payload_t expected_payload_q [$];
	payload_t want_item;
	int       mismatch_count = 0;
	int       items_sent = 0;
	int       idle_cycles = 0;
	int       ready_hold = 0;
	bit       steady_flow = 1'b0;

	byte_stuffed_frame_decoder #(
		.BUF_DEPTH(BUF_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.last_byte(last_byte),
		.frame_length(frame_length)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// gap length: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		if (steady_flow)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// any byte that is not a control code
	function automatic logic [7:0] random_data();
		return 8'($urandom_range(3, 255));
	endfunction

	// update the shadow state with one accepted link byte, queue any payload it releases
	function automatic void decode_link_byte(input logic [7:0] b);
		logic [7:0] v;
		payload_t   p;
		v = b;
		if (b == CODE_START) begin
			rx_open = 1'b1;
			esc_mark = 1'b0;
			fill = 0;
		end else if (rx_open) begin
			if (b == CODE_ESCAPE) begin
				esc_mark = 1'b1;
			end else if (b == CODE_STOP) begin
				for (int k = 0; k < fill; k++) begin
					p.data = frame_buf[k];
					p.last = (k == fill - 1);
					p.len = LEN_W'(fill);
					expected_payload_q.push_back(p);
				end
				rx_open = 1'b0;
				esc_mark = 1'b0;
				fill = 0;
			end else begin
				if (esc_mark) begin
					v = b - ESC_OFFSET;
					esc_mark = 1'b0;
				end
				frame_buf[fill] = v;
				fill++;
				// overflow drops the whole frame
				if (fill >= BUF_DEPTH) begin
					fill = 0;
					rx_open = 1'b0;
					esc_mark = 1'b0;
				end
			end
		end
	endfunction

	// drive one link byte, hold it until taken; valid stays high for a back-to-back item
	task automatic send_link_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		do
			@(posedge clk);
		while (!in_ready);
		decode_link_byte(b);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic test_plain_frames;
		steady_flow = 1'b1;
		send_link_byte(CODE_START);
		send_link_byte(8'h03);
		send_link_byte(8'hFF);
		send_link_byte(8'h7F);
		send_link_byte(8'h80);
		send_link_byte(CODE_STOP);
		steady_flow = 1'b0;
	endtask

	task automatic test_escapes;
		send_link_byte(CODE_START);
		send_link_byte(CODE_ESCAPE);
		send_link_byte(8'h03);
		send_link_byte(CODE_ESCAPE);
		send_link_byte(8'hFF);
		send_link_byte(CODE_ESCAPE);
		send_link_byte(8'h04);
		send_link_byte(CODE_STOP);
	endtask

	task automatic test_control_after_escape;
		// escape then start restarts the frame
		send_link_byte(CODE_START);
		send_link_byte(8'h55);
		send_link_byte(CODE_ESCAPE);
		send_link_byte(CODE_START);
		send_link_byte(8'hAA);
		// escape then escape keeps the mark
		send_link_byte(CODE_ESCAPE);
		send_link_byte(CODE_ESCAPE);
		send_link_byte(8'h10);
		// escape then stop still closes the frame
		send_link_byte(CODE_ESCAPE);
		send_link_byte(CODE_STOP);
	endtask

	task automatic test_empty_and_outside;
		send_link_byte(CODE_STOP);
		send_link_byte(CODE_ESCAPE);
		send_link_byte(8'hC3);
		send_link_byte(CODE_START);
		send_link_byte(CODE_STOP);
		send_link_byte(CODE_START);
		send_link_byte(CODE_ESCAPE);
		send_link_byte(CODE_STOP);
	endtask

	task automatic test_buffer_limits;
		// longest frame that fits
		steady_flow = 1'b1;
		send_link_byte(CODE_START);
		repeat (BUF_DEPTH - 1)
			send_link_byte(random_data());
		send_link_byte(CODE_STOP);
		steady_flow = 1'b0;
		// one byte more drops the frame, later bytes fall outside a frame
		send_link_byte(CODE_START);
		repeat (BUF_DEPTH)
			send_link_byte(random_data());
		send_link_byte(8'h5A);
		send_link_byte(CODE_STOP);
	endtask

	// well-formed frame with random content, sometimes broken
	task automatic send_random_frame;
		int len;
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			len = $urandom_range(1, 8);
		else if (r < 85)
			len = $urandom_range(9, 30);
		else if (r < 94)
			len = $urandom_range(31, BUF_DEPTH - 1);
		else
			len = $urandom_range(BUF_DEPTH, BUF_DEPTH + 4);
		send_link_byte(CODE_START);
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(0, 99);
			if (r < 2) begin
				send_link_byte(CODE_START);
			end else if (r < 25) begin
				send_link_byte(CODE_ESCAPE);
				send_link_byte(random_data());
			end else begin
				send_link_byte(random_data());
			end
		end
		r = $urandom_range(0, 99);
		if (r < 85) begin
			send_link_byte(CODE_STOP);
		end else if (r < 92) begin
			send_link_byte(CODE_ESCAPE);
			send_link_byte(CODE_STOP);
		end
	endtask

	task automatic test_random_traffic;
		int stop_at;
		stop_at = items_sent + 150;
		while (items_sent < stop_at) begin
			steady_flow = ($urandom_range(0, 4) == 0);
			// line noise between frames
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 3))
					send_link_byte(8'($urandom_range(0, 255)));
			send_random_frame();
		end
		steady_flow = 1'b0;
	endtask

	// sequence of tests
	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_plain_frames();
		test_escapes();
		test_control_after_escape();
		test_empty_and_outside();
		test_buffer_limits();
		test_random_traffic();
		in_valid <= 1'b0;
		while (expected_payload_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("[byte_stuffed_frame_decoder] OK");
		else
			$display("[byte_stuffed_frame_decoder] ERROR");
		$finish;
	end

	// output stalls
	always @(negedge clk) begin
		if (ready_hold > 0) begin
			out_ready <= 1'b0;
			ready_hold <= ready_hold - 1;
		end else begin
			out_ready <= 1'b1;
			ready_hold <= pick_gap();
		end
	end

	// compare each result item with the oldest expected payload
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_payload_q.size() == 0) begin
				$error("unexpected result item: out_byte %0h", out_byte);
				mismatch_count++;
			end else begin
				want_item = expected_payload_q.pop_front();
				if (out_byte !== want_item.data) begin
					$error("out_byte: expected %0h, got %0h", want_item.data, out_byte);
					mismatch_count++;
				end
				if (last_byte !== want_item.last) begin
					$error("last_byte: expected %0b, got %0b", want_item.last, last_byte);
					mismatch_count++;
				end
				if (frame_length !== want_item.len) begin
					$error("frame_length: expected %0d, got %0d", want_item.len,
						frame_length);
					mismatch_count++;
				end
			end
		end
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[byte_stuffed_frame_decoder] ERROR");
			$finish;
		end
	end

endmodule

[files.f]
+incdir+rtl
rtl/bsfd_pkg.sv
rtl/bsfd_ram.sv
rtl/bsfd_rx.sv
rtl/bsfd_tx.sv
rtl/byte_stuffed_frame_decoder.sv
bench/byte_stuffed_frame_decoder_tb.sv
